FILE: design/i2cssr_pkg.sv
// Package with the types, codes and constants of the sampled I2C slave receiver.
`timescale 1ns / 1ps

package i2cssr_pkg;

  localparam int unsigned AddrW   = 8;
  localparam int unsigned IdleW   = 8;
  localparam int unsigned StartW  = 20;
  localparam int unsigned BitToW  = 9;
  localparam int unsigned CfgW    = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned EventW  = 3;

  localparam logic [AddrW-1:0]  OwnAddressRst   = 8'h20;
  localparam logic [IdleW-1:0]  IdleSamplesRst  = 8'd15;
  localparam logic [StartW-1:0] StartTimeoutRst = 20'd640000;
  localparam logic [BitToW-1:0] BitTimeoutRst   = 9'd300;

  localparam logic [StartW-1:0] WaitMax  = 20'hFFFFF;
  localparam logic [BitToW-1:0] TimerMax = 9'h1FF;
  localparam logic [7:0]        IndexMax = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_ADDRESS   = 2'd0,
    REG_IDLE_SAMPLES  = 2'd1,
    REG_START_TIMEOUT = 2'd2,
    REG_BIT_TIMEOUT   = 2'd3
  } reg_idx_t;

  typedef enum logic [EventW-1:0] {
    EV_NONE     = 3'd0,
    EV_BYTE     = 3'd1,
    EV_STOP     = 3'd2,
    EV_WRONG    = 3'd3,
    EV_START_TO = 3'd4,
    EV_BIT_TO   = 3'd5
  } event_t;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_ARMED    = 7'b0000010,
    PH_WAIT_SCL = 7'b0000100,
    PH_GET_BIT  = 7'b0001000,
    PH_ACK_FALL = 7'b0010000,
    PH_ACK_RISE = 7'b0100000,
    PH_ACK_END  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [AddrW-1:0]  own_address;
    logic [IdleW-1:0]  idle_samples;
    logic [StartW-1:0] start_timeout;
    logic [BitToW-1:0] bit_timeout;
  } cfg_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [7:0]        data_byte;
    logic [7:0]        byte_index;
    logic              sda_drive_low;
  } result_t;

endpackage

FILE: design/i2cssr_if.sv
// Interfaces of the sample input channel and the result channel.
`timescale 1ns / 1ps

interface i2cssr_in_if;
  logic valid;
  logic ready;
  logic sda_sample;
  logic scl_sample;

  modport source (output valid, output sda_sample, output scl_sample, input ready);
  modport sink (input valid, input sda_sample, input scl_sample, output ready);
endinterface

interface i2cssr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic       sda_drive_low;

  modport source (output valid, output event_res, output data_byte, output byte_index,
                  output sda_drive_low, input ready);
  modport sink (input valid, input event_res, input data_byte, input byte_index,
                input sda_drive_low, output ready);
endinterface

FILE: design/i2cssr_cfg.sv
// Configuration register bank of the sampled I2C slave receiver.
`timescale 1ns / 1ps

module i2cssr_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [i2cssr_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [i2cssr_pkg::CfgW-1:0]         cfg_wdata,
  output i2cssr_pkg::cfg_t                    cfg
);

  i2cssr_pkg::cfg_t cfg_r;
  i2cssr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (i2cssr_pkg::reg_idx_t'(cfg_index))
        i2cssr_pkg::REG_OWN_ADDRESS:   cfg_nxt.own_address = cfg_wdata[i2cssr_pkg::AddrW-1:0];
        i2cssr_pkg::REG_IDLE_SAMPLES:  cfg_nxt.idle_samples = cfg_wdata[i2cssr_pkg::IdleW-1:0];
        i2cssr_pkg::REG_START_TIMEOUT: cfg_nxt.start_timeout = cfg_wdata[i2cssr_pkg::StartW-1:0];
        i2cssr_pkg::REG_BIT_TIMEOUT:   cfg_nxt.bit_timeout = cfg_wdata[i2cssr_pkg::BitToW-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address   <= i2cssr_pkg::OwnAddressRst;
      cfg_r.idle_samples  <= i2cssr_pkg::IdleSamplesRst;
      cfg_r.start_timeout <= i2cssr_pkg::StartTimeoutRst;
      cfg_r.bit_timeout   <= i2cssr_pkg::BitTimeoutRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/i2cssr_core.sv
// Bus state machine that advances by one line sample and forms that sample's result.
`timescale 1ns / 1ps

module i2cssr_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 sda,
  input  logic                 scl,
  input  i2cssr_pkg::cfg_t     cfg,
  output i2cssr_pkg::result_t  result
);

  i2cssr_pkg::phase_t                 phase_r, phase_nxt;
  logic [7:0]                         shift_byte_r, shift_byte_nxt;
  logic [3:0]                         bit_count_r, bit_count_nxt;
  logic [7:0]                         byte_count_r, byte_count_nxt;
  logic [i2cssr_pkg::StartW-1:0]      wait_counter_r, wait_counter_nxt;
  logic [i2cssr_pkg::BitToW-1:0]      phase_timer_r, phase_timer_nxt;
  logic                               prev_sda_r;
  logic                               ack_driving_r, ack_driving_nxt;

  logic [i2cssr_pkg::StartW-1:0]      wait_inc;
  logic [i2cssr_pkg::BitToW-1:0]      timer_inc;
  logic                               timer_expired;
  logic [7:0]                         shift_new;
  logic [3:0]                         bit_inc;
  logic [i2cssr_pkg::EventW-1:0]      event_nxt;
  logic [7:0]                         data_nxt;
  logic [7:0]                         index_nxt;

  assign wait_inc = (wait_counter_r < i2cssr_pkg::WaitMax) ? wait_counter_r + 1'b1
                                                           : wait_counter_r;
  assign timer_inc = (phase_timer_r < i2cssr_pkg::TimerMax) ? phase_timer_r + 1'b1
                                                            : phase_timer_r;
  assign timer_expired = timer_inc > cfg.bit_timeout;
  assign shift_new = {shift_byte_r[6:0], sda};
  assign bit_inc = bit_count_r + 1'b1;

  always_comb begin
    phase_nxt        = phase_r;
    shift_byte_nxt   = shift_byte_r;
    bit_count_nxt    = bit_count_r;
    byte_count_nxt   = byte_count_r;
    wait_counter_nxt = wait_counter_r;
    phase_timer_nxt  = phase_timer_r;
    ack_driving_nxt  = ack_driving_r;
    event_nxt        = i2cssr_pkg::EV_NONE;
    data_nxt         = 8'd0;
    index_nxt        = 8'd0;

    case (phase_r)
      i2cssr_pkg::PH_IDLE: begin
        if (sda && scl) begin
          wait_counter_nxt = wait_inc;
          if (wait_inc > {{(i2cssr_pkg::StartW - i2cssr_pkg::IdleW){1'b0}}, cfg.idle_samples})
          begin
            shift_byte_nxt   = 8'd0;
            bit_count_nxt    = 4'd0;
            byte_count_nxt   = 8'd0;
            wait_counter_nxt = '0;
            phase_nxt        = i2cssr_pkg::PH_ARMED;
          end
        end
      end
      i2cssr_pkg::PH_ARMED: begin
        if (!scl) begin
          phase_nxt        = i2cssr_pkg::PH_IDLE;
          wait_counter_nxt = '0;
          phase_timer_nxt  = '0;
          ack_driving_nxt  = 1'b0;
        end else if (!sda) begin
          wait_counter_nxt = '0;
          phase_nxt        = i2cssr_pkg::PH_WAIT_SCL;
        end else begin
          wait_counter_nxt = wait_inc;
          if (wait_inc > cfg.start_timeout) begin
            event_nxt        = i2cssr_pkg::EV_START_TO;
            phase_nxt        = i2cssr_pkg::PH_IDLE;
            wait_counter_nxt = '0;
            phase_timer_nxt  = '0;
            ack_driving_nxt  = 1'b0;
          end
        end
      end
      i2cssr_pkg::PH_WAIT_SCL: begin
        if (!scl) begin
          phase_nxt = i2cssr_pkg::PH_GET_BIT;
        end else if (sda && !prev_sda_r) begin
          event_nxt        = i2cssr_pkg::EV_STOP;
          phase_nxt        = i2cssr_pkg::PH_IDLE;
          wait_counter_nxt = '0;
          phase_timer_nxt  = '0;
          ack_driving_nxt  = 1'b0;
        end
      end
      i2cssr_pkg::PH_GET_BIT: begin
        if (scl) begin
          shift_byte_nxt = shift_new;
          bit_count_nxt  = bit_inc;
          phase_nxt      = i2cssr_pkg::PH_WAIT_SCL;
          if (bit_inc > 4'd7) begin
            data_nxt       = shift_new;
            shift_byte_nxt = 8'd0;
            bit_count_nxt  = 4'd0;
            if (byte_count_r == 8'd0 && shift_new != cfg.own_address) begin
              event_nxt        = i2cssr_pkg::EV_WRONG;
              phase_nxt        = i2cssr_pkg::PH_IDLE;
              wait_counter_nxt = '0;
              phase_timer_nxt  = '0;
              ack_driving_nxt  = 1'b0;
            end else begin
              event_nxt       = i2cssr_pkg::EV_BYTE;
              index_nxt       = byte_count_r;
              byte_count_nxt  = (byte_count_r < i2cssr_pkg::IndexMax) ? byte_count_r + 1'b1
                                                                       : byte_count_r;
              phase_timer_nxt = '0;
              phase_nxt       = i2cssr_pkg::PH_ACK_FALL;
            end
          end
        end
      end
      i2cssr_pkg::PH_ACK_FALL, i2cssr_pkg::PH_ACK_END: begin
        if (scl) begin
          phase_timer_nxt = timer_inc;
          if (timer_expired) begin
            event_nxt        = i2cssr_pkg::EV_BIT_TO;
            phase_nxt        = i2cssr_pkg::PH_IDLE;
            wait_counter_nxt = '0;
            phase_timer_nxt  = '0;
            ack_driving_nxt  = 1'b0;
          end
        end else begin
          phase_timer_nxt = '0;
          if (phase_r == i2cssr_pkg::PH_ACK_FALL) begin
            ack_driving_nxt = 1'b1;
            phase_nxt       = i2cssr_pkg::PH_ACK_RISE;
          end else begin
            ack_driving_nxt = 1'b0;
            phase_nxt       = i2cssr_pkg::PH_WAIT_SCL;
          end
        end
      end
      i2cssr_pkg::PH_ACK_RISE: begin
        if (!scl) begin
          phase_timer_nxt = timer_inc;
          if (timer_expired) begin
            event_nxt        = i2cssr_pkg::EV_BIT_TO;
            phase_nxt        = i2cssr_pkg::PH_IDLE;
            wait_counter_nxt = '0;
            phase_timer_nxt  = '0;
            ack_driving_nxt  = 1'b0;
          end
        end else begin
          phase_timer_nxt = '0;
          phase_nxt       = i2cssr_pkg::PH_ACK_END;
        end
      end
      default: begin
        phase_nxt        = i2cssr_pkg::PH_IDLE;
        wait_counter_nxt = '0;
        phase_timer_nxt  = '0;
        ack_driving_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= i2cssr_pkg::PH_IDLE;
      shift_byte_r   <= 8'd0;
      bit_count_r    <= 4'd0;
      byte_count_r   <= 8'd0;
      wait_counter_r <= '0;
      phase_timer_r  <= '0;
      prev_sda_r     <= 1'b0;
      ack_driving_r  <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      shift_byte_r   <= shift_byte_nxt;
      bit_count_r    <= bit_count_nxt;
      byte_count_r   <= byte_count_nxt;
      wait_counter_r <= wait_counter_nxt;
      phase_timer_r  <= phase_timer_nxt;
      prev_sda_r     <= sda;
      ack_driving_r  <= ack_driving_nxt;
    end
  end

  assign result.event_res     = event_nxt;
  assign result.data_byte     = data_nxt;
  assign result.byte_index    = index_nxt;
  assign result.sda_drive_low = ack_driving_nxt;

endmodule

FILE: design/i2c_sampled_slave_receiver.sv
// Top level of the sampled I2C slave receiver.
`timescale 1ns / 1ps

// The block takes one word per SDA/SCL sample pair on the in_chan channel and
// returns exactly one result word per sample on out_chan: an event code, the
// received byte and its position in the frame, and the acknowledge drive level.
// The user writes configuration through cfg_we, cfg_index and cfg_wdata only
// while the block is idle, which the block does not enforce; register 0 is
// the own address, 1 the idle sample count, 2 start and 3 bit timeout.
// A sample is processed in the cycle it is accepted and its result is held in
// the output register from the next cycle on; the throughput is one word per
// cycle while out_chan does not stall. The bus state and the output register
// are the only loop of the sample path, and both update in the same cycle.
// A synchronous reset with rst_n low puts the bus state machine into idle wait,
// loads the register reset values and empties the output register.
// When the receiver stalls, the result stays in the output register and
// in_chan.ready drops until it is taken; no sample is lost or dropped.

module i2c_sampled_slave_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  i2cssr_in_if.sink                       in_chan,
  i2cssr_out_if.source                    out_chan,
  input  logic                            cfg_we,
  input  logic [i2cssr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [i2cssr_pkg::CfgW-1:0]     cfg_wdata
);

  i2cssr_pkg::cfg_t     cfg;
  i2cssr_pkg::result_t  result;
  i2cssr_pkg::result_t  result_r;
  logic                 out_valid_r;
  logic                 in_ready;
  logic                 step_en;

  assign in_ready = !out_valid_r || out_chan.ready;
  assign step_en  = in_chan.valid && in_ready;

  i2cssr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  i2cssr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .sda     (in_chan.sda_sample),
    .scl     (in_chan.scl_sample),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      result_r <= result;
    end
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.event_res     = result_r.event_res;
  assign out_chan.data_byte     = result_r.data_byte;
  assign out_chan.byte_index    = result_r.byte_index;
  assign out_chan.sda_drive_low = result_r.sda_drive_low;

endmodule

FILE: design/i2cssr_checker.sv
// Port-level checker of the sampled I2C slave receiver and its bind statement.
`timescale 1ns / 1ps

module i2cssr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_res,
  input logic [7:0] data_byte,
  input logic [7:0] byte_index,
  input logic       sda_drive_low
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(data_byte))
    else $error("Stalled result word changed or was dropped.");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != i2cssr_pkg::EV_BYTE && event_res != i2cssr_pkg::EV_WRONG
    |-> data_byte == 8'd0 && byte_index == 8'd0)
    else $error("Byte fields set on a word without a byte.");

  a_wrong_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == i2cssr_pkg::EV_WRONG |-> byte_index == 8'd0)
    else $error("Wrong address reported on a byte other than the first.");

  a_release_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == i2cssr_pkg::EV_STOP || event_res == i2cssr_pkg::EV_WRONG ||
                  event_res == i2cssr_pkg::EV_START_TO || event_res == i2cssr_pkg::EV_BIT_TO)
    |-> !sda_drive_low)
    else $error("SDA still driven low after the frame ended.");

endmodule

bind i2c_sampled_slave_receiver i2cssr_checker u_i2cssr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .event_res     (out_chan.event_res),
  .data_byte     (out_chan.data_byte),
  .byte_index    (out_chan.byte_index),
  .sda_drive_low (out_chan.sda_drive_low)
);
